// ===== sv/deq_pkg.sv =====
// Shared types, constants and helpers for the double-ended queue unit
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DEPTH        = 16;
    localparam int WORD_WIDTH   = 32;
    localparam int DATA_W       = 32;
    localparam int ITEM_COUNT_W = 5;
    localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t            opcode;
        logic signed [31:0] push_data;
    } deq_req_t;

    typedef struct packed {
        logic signed [31:0] pop_data;
        logic               op_error;
        logic [4:0]         item_count;
    } deq_rsp_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } deq_cmd_t;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(i + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(i - 1'b1);
    endfunction

    function automatic logic signed [DATA_W-1:0] to_out_word(
        input logic [WORD_WIDTH-1:0] w
    );
        logic signed [WORD_WIDTH-1:0] s;
        s = $signed(w);
        return DATA_W'(s);
    endfunction

endpackage

`default_nettype wire

// ===== sv/deq_ram.sv =====
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic                                  re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/deq_ctrl.sv =====
// Controller state machine sequencing capture, execute and result load
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output deq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        cmd.capture = (state_reg == ST_IDLE) && req_valid;
        cmd.execute = (state_reg == ST_EXEC);
        cmd.load    = (state_reg == ST_LOAD) && (!rsp_valid_reg || !rsp_stall);

        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (cmd.load)
        begin
            rsp_valid_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (cmd.load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

`ifndef ASSERT_OFF
    a_capture_then_execute: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.execute)
        else $error("execute did not follow capture");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> rsp_valid)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// ===== sv/deq_datapath.sv =====
// Datapath: item register, pointers, count, word store and result register
`timescale 1ns / 1ps
`default_nettype none

module deq_datapath
    import deq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire deq_cmd_t cmd,
    input  wire deq_req_t req,
    output deq_rsp_t      rsp
);

    opcode_t               op_reg;
    logic [WORD_WIDTH-1:0] word_reg;
    logic [IDX_W-1:0]      front_reg;
    logic [IDX_W-1:0]      front_next;
    logic [IDX_W-1:0]      rear_reg;
    logic [IDX_W-1:0]      rear_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic                  pop_ok_reg;
    logic                  err_reg;
    deq_rsp_t              rsp_reg;

    logic                  is_push;
    logic                  push_ok;
    logic                  pop_ok;
    logic [IDX_W-1:0]      ram_addr;
    logic [WORD_WIDTH-1:0] ram_rd_data;

    always_comb
    begin
        is_push    = (op_reg == OP_PUSH_REAR) || (op_reg == OP_PUSH_FRONT);
        push_ok    = is_push && (count_reg != COUNT_W'(DEPTH));
        pop_ok     = !is_push && (count_reg != '0);
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        ram_addr   = rear_reg;
        case (op_reg)
            OP_PUSH_REAR:
            begin
                ram_addr  = rear_reg;
                rear_next = idx_next(rear_reg);
            end
            OP_PUSH_FRONT:
            begin
                ram_addr   = idx_prev(front_reg);
                front_next = idx_prev(front_reg);
            end
            OP_POP_FRONT:
            begin
                ram_addr   = front_reg;
                front_next = idx_next(front_reg);
            end
            OP_POP_REAR:
            begin
                ram_addr  = idx_prev(rear_reg);
                rear_next = idx_prev(rear_reg);
            end
            default:
            begin
                ram_addr = rear_reg;
            end
        endcase
        if (push_ok)
        begin
            count_next = COUNT_W'(count_reg + 1'b1);
        end
        else if (pop_ok)
        begin
            count_next = COUNT_W'(count_reg - 1'b1);
        end
    end

    deq_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (cmd.execute && push_ok),
        .re      (cmd.execute && pop_ok),
        .addr    (ram_addr),
        .wr_data (word_reg),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.execute && (push_ok || pop_ok))
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= req.opcode;
            word_reg <= WORD_WIDTH'($unsigned(req.push_data));
        end
        if (cmd.execute)
        begin
            pop_ok_reg <= pop_ok;
            err_reg    <= !(push_ok || pop_ok);
        end
        if (cmd.load)
        begin
            rsp_reg.pop_data   <= pop_ok_reg ? to_out_word(ram_rd_data) : '0;
            rsp_reg.op_error   <= err_reg;
            rsp_reg.item_count <= ITEM_COUNT_W'(count_reg);
        end
    end

    assign rsp = rsp_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("stored count exceeds depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && push_ok |=> count_reg == COUNT_W'($past(count_reg) + 1'b1))
        else $error("accepted push did not grow the count");
`endif

endmodule

`default_nettype wire

// ===== sv/double_ended_queue_unit.sv =====
// Each request is handled in turn: capture, store access, result load; the next is not
// taken before the last one's result is loaded, set by the single-port word store with
// its registered read. The load waits while an earlier result beat is stalled.
// The next request is taken while a result beat still waits on a stalled output.
// Reset: asynchronous, active low; queue empty, both pointers at zero, no result valid.
// The word store is not cleared; entries are read only after a push writes them.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_unit
    import deq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire deq_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output deq_rsp_t      rsp
);

    deq_cmd_t cmd;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    deq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== verif/deque_scoreboard_pkg.sv =====
// Shadow deque and result scoreboard for the double-ended queue unit testbench
`timescale 1ns / 1ps

package deque_scoreboard_pkg;
    import deq_pkg::*;

    class deque_scoreboard;
        logic signed [DATA_W-1:0] shadow_words [DEPTH];
        logic [IDX_W-1:0]         shadow_front;
        logic [IDX_W-1:0]         shadow_rear;
        int unsigned              shadow_count;
        deq_rsp_t                 rsp_due [$];
        int unsigned              mismatches;
        int unsigned              beats_checked;
        int unsigned              flagged_errors;
        int unsigned              full_hits;
        int unsigned              op_seen [4];

        function new();
            shadow_front   = '0;
            shadow_rear    = '0;
            shadow_count   = 0;
            mismatches     = 0;
            beats_checked  = 0;
            flagged_errors = 0;
            full_hits      = 0;
            foreach (op_seen[i])
                op_seen[i] = 0;
        endfunction

        function int unsigned pending();
            return rsp_due.size();
        endfunction

        // Apply one accepted request beat to the shadow deque and queue its result.
        function void note_request(deq_req_t item);
            deq_rsp_t due;
            due = '0;
            op_seen[item.opcode]++;
            case (item.opcode)
                OP_PUSH_REAR, OP_PUSH_FRONT:
                begin
                    if (shadow_count >= DEPTH)
                    begin
                        due.op_error = 1'b1;
                    end
                    else if (item.opcode == OP_PUSH_REAR)
                    begin
                        shadow_words[shadow_rear] = item.push_data;
                        shadow_rear = IDX_W'((int'(shadow_rear) + 1) % DEPTH);
                        shadow_count++;
                    end
                    else
                    begin
                        shadow_front = IDX_W'((int'(shadow_front) + DEPTH - 1) % DEPTH);
                        shadow_words[shadow_front] = item.push_data;
                        shadow_count++;
                    end
                end
                default:
                begin
                    if (shadow_count == 0)
                    begin
                        due.op_error = 1'b1;
                    end
                    else if (item.opcode == OP_POP_FRONT)
                    begin
                        due.pop_data = shadow_words[shadow_front];
                        shadow_front = IDX_W'((int'(shadow_front) + 1) % DEPTH);
                        shadow_count--;
                    end
                    else
                    begin
                        shadow_rear = IDX_W'((int'(shadow_rear) + DEPTH - 1) % DEPTH);
                        due.pop_data = shadow_words[shadow_rear];
                        shadow_count--;
                    end
                end
            endcase
            due.item_count = ITEM_COUNT_W'(shadow_count);
            if (due.op_error)
                flagged_errors++;
            if (shadow_count == DEPTH)
                full_hits++;
            rsp_due.push_back(due);
        endfunction

        function void check_response(deq_rsp_t got);
            deq_rsp_t want;
            beats_checked++;
            if (rsp_due.size() == 0)
            begin
                $error("unexpected result beat: pop_data %0d op_error %0b item_count %0d",
                       got.pop_data, got.op_error, got.item_count);
                mismatches++;
                return;
            end
            want = rsp_due.pop_front();
            if (got.pop_data !== want.pop_data)
            begin
                $error("pop_data: expected %0d, got %0d", want.pop_data, got.pop_data);
                mismatches++;
            end
            if (got.op_error !== want.op_error)
            begin
                $error("op_error: expected %0b, got %0b", want.op_error, got.op_error);
                mismatches++;
            end
            if (got.item_count !== want.item_count)
            begin
                $error("item_count: expected %0d, got %0d", want.item_count, got.item_count);
                mismatches++;
            end
        endfunction

        function void check_drained();
            if (rsp_due.size() != 0)
            begin
                $error("%0d result beats never arrived", rsp_due.size());
                mismatches += rsp_due.size();
            end
        endfunction
    endclass

endpackage

// ===== verif/tb_double_ended_queue_unit.sv =====
// Testbench for double_ended_queue_unit: directed and random deque traffic against a shadow deque
`timescale 1ns / 1ps

module tb_double_ended_queue_unit;
    import deq_pkg::*;
    import deque_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 180;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    deq_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    deq_rsp_t rsp;

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned hold_off_left;
    int unsigned cycles;

    deque_scoreboard sb;

    logic [31:0] extreme_words [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                       32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                                       32'h0000_0001, 32'hFFFF_FFFE};

    double_ended_queue_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
        end
    end

    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_off_left--;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_item(input opcode_t op, input logic [31:0] word);
        deq_req_t item;
        item.opcode    = op;
        item.push_data = word;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_directed();
        opcode_t op;
        send_item(OP_POP_FRONT, 32'h1234_5678);
        send_item(OP_POP_REAR, 32'hFFFF_FFFF);
        for (int i = 0; i < DEPTH; i++)
        begin
            op = i[0] ? OP_PUSH_FRONT : OP_PUSH_REAR;
            send_item(op, extreme_words[i % 8]);
        end
        send_item(OP_PUSH_REAR, 32'h7FFF_FFFF);
        send_item(OP_PUSH_FRONT, 32'h8000_0000);
        send_item(OP_POP_FRONT, 32'h0);
        send_item(OP_POP_REAR, 32'h0);
    endtask

    // Runs of fill-leaning, drain-leaning or balanced traffic with random words.
    task automatic run_random(input int unsigned n);
        int unsigned left;
        int unsigned run_len;
        int unsigned pop_bias;
        opcode_t     op;
        logic [31:0] word;
        left = n;
        while (left > 0)
        begin
            run_len = $urandom_range(4, 40);
            case ($urandom_range(3))
                0:       pop_bias = 15;
                1:       pop_bias = 85;
                default: pop_bias = 50;
            endcase
            for (int i = 0; i < run_len && left > 0; i++)
            begin
                if ($urandom_range(99) < pop_bias)
                    op = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
                else
                    op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
                word = ($urandom_range(7) == 0) ? extreme_words[$urandom_range(7)] : $urandom;
                send_item(op, word);
                left--;
            end
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(PHASE_ITEMS);

        send_idle_pct = 84;
        run_random(PHASE_ITEMS);

        send_idle_pct = 0;
        stall_pct     = 84;
        run_random(PHASE_ITEMS);

        send_idle_pct = 35;
        stall_pct     = 35;
        run_random(PHASE_ITEMS);

        // Hold the result side off while requests keep coming, then drain fully.
        send_idle_pct = 0;
        stall_pct     = 0;
        @(negedge clk);
        hold_off_left = 150;
        run_random(60);
        wait_drained();

        send_idle_pct = 35;
        stall_pct     = 35;
        run_random(100);

        wait_drained();
        sb.check_drained();

        $display("Covered %0d request beats: %0d push rear, %0d push front, %0d pop front, %0d pop rear",
                 sb.op_seen[0] + sb.op_seen[1] + sb.op_seen[2] + sb.op_seen[3],
                 sb.op_seen[OP_PUSH_REAR], sb.op_seen[OP_PUSH_FRONT],
                 sb.op_seen[OP_POP_FRONT], sb.op_seen[OP_POP_REAR]);
        $display("%0d result beats checked, %0d with error flag, %0d leaving the queue full",
                 sb.beats_checked, sb.flagged_errors, sb.full_hits);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
